// ----- rtl/keyed_priority_task_table_core_defines.svh -----
// ---------------------------------------------------------------------------
// Keyed priority task table: assertion macros
// Concurrent checks on the core clock with the synchronous reset masked.
// ---------------------------------------------------------------------------
`ifndef KEYED_PRIORITY_TASK_TABLE_CORE_DEFINES_SVH
`define KEYED_PRIORITY_TASK_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPTT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KPTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/kptt_pkg.sv -----
// ---------------------------------------------------------------------------
// Keyed priority task table package
// Field widths, command and status codes, and the layout of one table entry.
// ---------------------------------------------------------------------------
package kptt_pkg;

   localparam int CMD_W    = 2;
   localparam int USER_W   = 16;
   localparam int ID_W     = 16;
   localparam int PRIO_W   = 30;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_CHANGE = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_EXEC   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_UNKNOWN   = 3'd3,
      ST_DUPLICATE = 3'd4
   } status_type;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   task_id;
      logic [PRIO_W-1:0] prio;
      logic [USER_W-1:0] owner;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ----- rtl/kptt_req_if.sv -----
// ---------------------------------------------------------------------------
// Keyed priority task table request channel
// Valid/ready channel that carries one command with its operands.
// ---------------------------------------------------------------------------
interface kptt_req_if;
   import kptt_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [USER_W-1:0] user_id;
   logic [ID_W-1:0]   task_id;
   logic [PRIO_W-1:0] priority_req;

   modport source (output valid, output command, output user_id, output task_id,
                   output priority_req, input ready);
   modport sink (input valid, input command, input user_id, input task_id,
                 input priority_req, output ready);
endinterface

// ----- rtl/kptt_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Keyed priority task table response channel
// Valid/ready channel that carries the owner and status of one command.
// ---------------------------------------------------------------------------
interface kptt_rsp_if;
   import kptt_pkg::*;

   logic                valid;
   logic                ready;
   logic [USER_W-1:0]   owner;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output owner, output status, input ready);
   modport sink (input valid, input owner, input status, output ready);
endinterface

// ----- rtl/keyed_priority_task_table_core.sv -----
// After a request is accepted, the scan reads every entry and the finish state
// registers the response; no new request is taken until then. Each command reads all
// CAPACITY entries through the single read port of the table RAM, one entry a cycle.
// A finished response waits in its output register while the next request is taken.
// Reset: a clearing pass writes every entry empty while ready is held low.
// ---------------------------------------------------------------------------
// Keyed priority task table core
// Table of tasks keyed by id; add, change priority, remove and execute-top,
// each done by a sequential scan with one shared compare unit.
// ---------------------------------------------------------------------------
`include "keyed_priority_task_table_core_defines.svh"

module keyed_priority_task_table_core #(
   parameter int CAPACITY = 64
) (
   input logic       clock,
   input logic       reset,
   kptt_req_if.sink  req_if,
   kptt_rsp_if.source rsp_if
);
   import kptt_pkg::*;

   localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int KeyW = PRIO_W + ID_W;
   localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);
   localparam logic [CntW-1:0] CntLast = CntW'(CAPACITY - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                chk_ff, chk_in;
   logic [IdxW-1:0]     chk_idx_ff, chk_idx_in;

   cmd_type             cmd_ff, cmd_in;
   logic [USER_W-1:0]   user_ff, user_in;
   logic [ID_W-1:0]     task_ff, task_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;

   logic                found_ff, found_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [USER_W-1:0]   owner_ff, owner_in;
   logic [KeyW-1:0]     key_ff, key_in;
   logic                free_ff, free_in;
   logic [IdxW-1:0]     free_idx_ff, free_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [USER_W-1:0]   rsp_owner_ff, rsp_owner_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                ram_we;
   logic [IdxW-1:0]     ram_wr_addr;
   entry_type           wr_ent;
   logic                ram_re;
   logic [ENTRY_W-1:0]  ram_rd_data;
   entry_type           rd_ent;
   logic [KeyW-1:0]     rd_key;
   logic                take;

   kptt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_ent),
      .rd_en   (ram_re),
      .rd_addr (cnt_ff[IdxW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rd_ent = entry_type'(ram_rd_data);
   assign rd_key = {rd_ent.prio, rd_ent.task_id};

   // Execute-top keeps the largest (priority, id) pair; the other commands look
   // for the entry whose id matches the request.
   always_comb begin
      if (cmd_ff == CMD_EXEC) begin
         take = rd_ent.valid && (!found_ff || (rd_key > key_ff));
      end else begin
         take = rd_ent.valid && (rd_ent.task_id == task_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      chk_in        = chk_ff;
      chk_idx_in    = chk_idx_ff;
      cmd_in        = cmd_ff;
      user_in       = user_ff;
      task_in       = task_ff;
      prio_in       = prio_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      owner_in      = owner_ff;
      key_in        = key_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = idx_ff;
      wr_ent        = '0;
      ram_re        = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (chk_ff) begin
         if (take) begin
            found_in = 1'b1;
            idx_in   = chk_idx_ff;
            owner_in = rd_ent.owner;
            key_in   = rd_key;
         end
         if (!rd_ent.valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = cnt_ff[IdxW-1:0];
            if (cnt_ff == CntLast) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               cmd_in   = cmd_type'(req_if.command);
               user_in  = req_if.user_id;
               task_in  = req_if.task_id;
               prio_in  = req_if.priority_req;
               found_in = 1'b0;
               free_in  = 1'b0;
               cnt_in   = '0;
               chk_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff < CntFull) begin
               ram_re     = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = cnt_ff[IdxW-1:0];
            end else begin
               // The last entry is compared in this cycle.
               chk_in   = 1'b0;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_owner_in  = '0;
               rsp_status_in = ST_DONE;
               state_in      = S_IDLE;
               case (cmd_ff)
                  CMD_ADD: begin
                     if (found_ff) begin
                        rsp_status_in = ST_DUPLICATE;
                     end else if (!free_ff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ram_we         = 1'b1;
                        ram_wr_addr    = free_idx_ff;
                        wr_ent.valid   = 1'b1;
                        wr_ent.task_id = task_ff;
                        wr_ent.prio    = prio_ff;
                        wr_ent.owner   = user_ff;
                     end
                  end
                  CMD_CHANGE: begin
                     if (!found_ff) begin
                        rsp_status_in = ST_UNKNOWN;
                     end else begin
                        ram_we         = 1'b1;
                        wr_ent.valid   = 1'b1;
                        wr_ent.task_id = task_ff;
                        wr_ent.prio    = prio_ff;
                        wr_ent.owner   = owner_ff;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!found_ff) begin
                        rsp_status_in = ST_UNKNOWN;
                     end else begin
                        ram_we = 1'b1;
                     end
                  end
                  CMD_EXEC: begin
                     if (!found_ff) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        ram_we       = 1'b1;
                        rsp_owner_in = owner_ff;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_DONE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         chk_ff       <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_ff       <= chk_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_idx_ff    <= chk_idx_in;
      cmd_ff        <= cmd_in;
      user_ff       <= user_in;
      task_ff       <= task_in;
      prio_ff       <= prio_in;
      idx_ff        <= idx_in;
      owner_ff      <= owner_in;
      key_ff        <= key_in;
      free_idx_ff   <= free_idx_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.owner  = rsp_owner_ff;
   assign rsp_if.status = rsp_status_ff;

   `KPTT_ASSERT_SAME(a_write_phase, ram_we, (state_ff == S_CLEAR || state_ff == S_FINISH),
                     "table written outside clear or finish")
   `KPTT_ASSERT_SAME(a_error_owner, rsp_valid_ff && rsp_status_ff != ST_DONE,
                     rsp_owner_ff == '0, "failed command reports an owner")
   `KPTT_ASSERT_SAME(a_cnt_range, state_ff == S_SCAN, cnt_ff <= CntFull,
                     "scan counter past the table size")
   `KPTT_ASSERT_NEXT(a_scan_length, state_ff == S_SCAN && cnt_ff != CntFull,
                     state_ff == S_SCAN, "scan ended before all entries were read")

endmodule

// ----- rtl/kptt_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module kptt_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
